FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/frsb_pkg.sv
// Package: types, sizes and helper functions of the frame ring sequence buffer.
package frsb_pkg;

   localparam int MAX_FRAMES  = 32;
   localparam int MAX_DIM     = 40;

   localparam int CFG_W       = 6;
   localparam int CSR_IDX_W   = 1;
   localparam int ELEM_W      = 32;
   localparam int POS_W       = 5;
   localparam int CMD_W       = 2;

   localparam int SLOT_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FRM_W       = $clog2(MAX_FRAMES + 1);
   localparam int DIM_W       = $clog2(MAX_DIM + 1);
   localparam int DEPTH       = MAX_FRAMES * MAX_DIM;
   localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int X_W         = ((SLOT_W > POS_W) ? SLOT_W : POS_W) + 1;
   localparam int STEP_W      = $clog2(X_W + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(32);
   localparam logic [CFG_W-1:0] DIM_RESET    = CFG_W'(40);

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DIM    = CSR_IDX_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DATA  = 2'd0,
      ST_PAD   = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      status_type              kind;
      logic [SLOT_W-1:0]       slot;
      logic [DIM_W-1:0]        dim;
   } job_type;

   typedef struct packed {
      logic queue_full;
      logic drained;
   } back_status_type;

   function automatic logic [FRM_W-1:0] eff_frames(input logic [CFG_W-1:0] cfg);
      logic [FRM_W-1:0] res;
      if (32'(cfg) > MAX_FRAMES) res = FRM_W'(MAX_FRAMES);
      else res = FRM_W'(cfg);
      return res;
   endfunction

   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] cfg);
      logic [DIM_W-1:0] res;
      if (cfg == '0) res = DIM_W'(1);
      else if (32'(cfg) > MAX_DIM) res = DIM_W'(MAX_DIM);
      else res = DIM_W'(cfg);
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] slot);
      logic [31:0] prod;
      prod = 32'(slot) * MAX_DIM;
      return prod[ADDR_W-1:0];
   endfunction

endpackage

FILE: rtl/frsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/frsb_mod.sv
// Restoring remainder unit: one dividend bit per cycle.
module frsb_mod
   import frsb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [X_W-1:0]    dividend,
   input  logic [FRM_W-1:0]  divisor,
   output logic              done,
   output logic [SLOT_W-1:0] remainder
);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [FRM_W-1:0]  d_ff, d_in;
   logic [FRM_W-1:0]  r_ff, r_in;
   logic [FRM_W:0]    trial;

   always_comb begin
      run_in  = run_ff;
      done_in = done_ff;
      step_in = step_ff;
      x_in    = x_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      trial   = {r_ff, x_ff[X_W-1]};
      if (start) begin
         run_in  = 1'b1;
         done_in = 1'b0;
         step_in = STEP_W'(X_W);
         x_in    = dividend;
         d_in    = divisor;
         r_in    = '0;
      end else if (run_ff) begin
         x_in = {x_ff[X_W-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = FRM_W'(trial - {1'b0, d_ff});
         end else begin
            r_in = FRM_W'(trial);
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      d_ff    <= d_in;
      r_ff    <= r_in;
   end

   assign done      = done_ff;
   assign remainder = SLOT_W'(r_ff);

endmodule

FILE: rtl/frsb_fifo.sv
// Short job queue between front and back ends.
module frsb_fifo
   import frsb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign full     = (32'(count_ff) == QUEUE_DEPTH);

endmodule

FILE: rtl/frsb_front.sv
// Front end: takes items, keeps the ring pointers, writes pushes, queues read jobs.
module frsb_front
   import frsb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [ELEM_W-1:0]     req_element_value,
   input  logic [POS_W-1:0]      req_seq_position,
   input  logic [FRM_W-1:0]      frames,
   input  logic [DIM_W-1:0]      dim,
   input  back_status_type       back_status,
   output logic                  wr_en,
   output logic [ADDR_W-1:0]     wr_addr,
   output logic [ELEM_W-1:0]     wr_data,
   output logic                  job_push,
   output job_type               job
);

   typedef enum logic [1:0] {
      FS_IDLE = 2'b01,
      FS_MOD  = 2'b10
   } front_state_type;

   front_state_type   state_ff, state_in;
   logic              item_ff, item_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic [ELEM_W-1:0] val_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic              full_ff, full_in;
   logic [DIM_W-1:0]  count_ff, count_in;
   logic              done;
   logic              accept;
   logic [FRM_W-1:0]  valid_cnt;
   logic              mod_start;
   logic              mod_done;
   logic [SLOT_W-1:0] mod_rem;
   logic [X_W-1:0]    mod_x;

   frsb_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_x),
      .divisor   (frames),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign mod_x = full_ff ? (X_W'(head_ff) + X_W'(pos_ff)) : X_W'(pos_ff);

   always_comb begin
      valid_cnt = full_ff ? frames : FRM_W'(head_ff);
      if (32'(valid_cnt) > 32'(frames)) valid_cnt = frames;
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      full_in   = full_ff;
      count_in  = count_ff;
      done      = 1'b0;
      mod_start = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = slot_base(head_ff) + ADDR_W'(count_ff);
      wr_data   = val_ff;
      job_push  = 1'b0;
      job.kind  = ST_EMPTY;
      job.slot  = mod_rem;
      job.dim   = dim;
      unique case (state_ff)
         FS_IDLE: begin
            if (item_ff) begin
               unique case (cmd_ff)
                  CMD_PUSH: begin
                     if (frames == '0) begin
                        done = 1'b1;
                     end else if (back_status.drained) begin
                        done  = 1'b1;
                        wr_en = 1'b1;
                        if (32'(count_ff) + 1 >= 32'(dim)) begin
                           count_in = '0;
                           if (32'(head_ff) + 1 >= 32'(frames)) begin
                              head_in = '0;
                              full_in = 1'b1;
                           end else begin
                              head_in = head_ff + SLOT_W'(1);
                           end
                        end else begin
                           count_in = count_ff + DIM_W'(1);
                        end
                     end
                  end
                  CMD_READ: begin
                     if (valid_cnt == '0) begin
                        if (!back_status.queue_full) begin
                           job_push = 1'b1;
                           job.kind = ST_EMPTY;
                           done     = 1'b1;
                        end
                     end else if (32'(pos_ff) >= 32'(valid_cnt)) begin
                        if (!back_status.queue_full) begin
                           job_push = 1'b1;
                           job.kind = ST_PAD;
                           done     = 1'b1;
                        end
                     end else begin
                        mod_start = 1'b1;
                        state_in  = FS_MOD;
                     end
                  end
                  CMD_CLEAR: begin
                     head_in  = '0;
                     full_in  = 1'b0;
                     count_in = '0;
                     done     = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         FS_MOD: begin
            if (mod_done && !back_status.queue_full) begin
               job_push = 1'b1;
               job.kind = ST_DATA;
               done     = 1'b1;
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   assign busy   = item_ff && !done;
   assign accept = start && !busy;

   always_comb begin
      item_in = item_ff;
      if (accept) item_in = 1'b1;
      else if (done) item_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         item_ff  <= 1'b0;
         head_ff  <= '0;
         full_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         item_ff  <= item_in;
         head_ff  <= head_in;
         full_ff  <= full_in;
         count_ff <= count_in;
      end
      if (accept) begin
         cmd_ff <= req_command;
         val_ff <= req_element_value;
         pos_ff <= req_seq_position;
      end
   end

endmodule

FILE: rtl/frsb_back.sv
// Back end: walks one read job a cycle per element and drives the results.
module frsb_back
   import frsb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  job_type            head_job,
   input  logic               queue_empty,
   output logic               pop,
   output logic               idle,
   output logic [ADDR_W-1:0]  rd_addr,
   input  logic [ELEM_W-1:0]  rd_data,
   output logic               rsp_strobe,
   output logic [ELEM_W-1:0]  rsp_sample_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last_of_frame
);

   typedef enum logic [1:0] {
      BS_IDLE = 2'b01,
      BS_RUN  = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [DIM_W-1:0]  idx_ff, idx_in;
   logic              meta_valid_ff, meta_valid_in;
   status_type        meta_kind_ff, meta_kind_in;
   logic              meta_last_ff, meta_last_in;
   logic              last;

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      base_in       = base_ff;
      idx_in        = idx_ff;
      pop           = 1'b0;
      meta_valid_in = 1'b0;
      meta_kind_in  = job_ff.kind;
      last          = (job_ff.kind == ST_EMPTY) || (32'(idx_ff) + 1 == 32'(job_ff.dim));
      meta_last_in  = last;
      unique case (state_ff)
         BS_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               job_in   = head_job;
               base_in  = slot_base(head_job.slot);
               idx_in   = '0;
               state_in = BS_RUN;
            end
         end
         BS_RUN: begin
            meta_valid_in = 1'b1;
            if (last) begin
               state_in = BS_IDLE;
            end else begin
               idx_in = idx_ff + DIM_W'(1);
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BS_IDLE;
         meta_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         meta_valid_ff <= meta_valid_in;
      end
      job_ff       <= job_in;
      base_ff      <= base_in;
      idx_ff       <= idx_in;
      meta_kind_ff <= meta_kind_in;
      meta_last_ff <= meta_last_in;
   end

   assign idle              = (state_ff == BS_IDLE);
   assign rd_addr           = base_ff + ADDR_W'(idx_ff);
   assign rsp_strobe        = meta_valid_ff;
   assign rsp_sample_value  = (meta_kind_ff == ST_DATA) ? rd_data : '0;
   assign rsp_status        = meta_kind_ff;
   assign rsp_last_of_frame = meta_last_ff;

endmodule

FILE: rtl/frame_ring_sequence_buffer_core.sv
// Data reads first pass through the 6-step slot remainder unit in the front end;
// pad and empty reads are queued without it.
// Throughput: pushes and clears one per cycle; a data or pad read gives dim_in_use results
// (an empty read one), one per cycle from the single RAM read port, idle between reads.
// A push waits until queued reads are finished. Results cannot be stalled.
// Reset clears head, full flag and element count, loads 32 frames / 40 elements; store kept.
module frame_ring_sequence_buffer_core
   import frsb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [ELEM_W-1:0]    req_element_value,
   input  logic [POS_W-1:0]     req_seq_position,
   output logic                 rsp_strobe,
   output logic [ELEM_W-1:0]    rsp_sample_value,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last_of_frame,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data
);

   logic [CFG_W-1:0]  frames_cfg_ff, frames_cfg_in;
   logic [CFG_W-1:0]  dim_cfg_ff, dim_cfg_in;
   back_status_type   back_status;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ELEM_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [ELEM_W-1:0] rd_data;
   logic              job_push;
   job_type           job;
   job_type           head_job;
   logic              q_empty;
   logic              q_full;
   logic              q_pop;
   logic              back_idle;

   always_comb begin
      frames_cfg_in = frames_cfg_ff;
      dim_cfg_in    = dim_cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAMES: frames_cfg_in = csr_write_data;
            CSR_DIM:    dim_cfg_in    = csr_write_data;
            default:    frames_cfg_in = frames_cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_cfg_ff <= FRAMES_RESET;
         dim_cfg_ff    <= DIM_RESET;
      end else begin
         frames_cfg_ff <= frames_cfg_in;
         dim_cfg_ff    <= dim_cfg_in;
      end
   end

   assign back_status.queue_full = q_full;
   assign back_status.drained    = q_empty && back_idle;

   frsb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_element_value (req_element_value),
      .req_seq_position  (req_seq_position),
      .frames            (eff_frames(frames_cfg_ff)),
      .dim               (eff_dim(dim_cfg_ff)),
      .back_status       (back_status),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .job_push          (job_push),
      .job               (job)
   );

   frsb_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   frsb_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   frsb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_job          (head_job),
      .queue_empty       (q_empty),
      .pop               (q_pop),
      .idle              (back_idle),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_status        (rsp_status),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

FILE: rtl/frsb_checker.sv
// Port-level checker for the frame ring sequence buffer, bound to the top level.
`include "assert_macros.svh"

module frsb_checker
   import frsb_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_strobe,
   input logic [ELEM_W-1:0] rsp_sample_value,
   input logic [1:0]        rsp_status,
   input logic              rsp_last_of_frame
);

   `ASSERT_IMPL(a_empty_single, clock, reset, rsp_strobe && rsp_status == ST_EMPTY, rsp_last_of_frame && rsp_sample_value == '0)
   `ASSERT_IMPL(a_pad_zero, clock, reset, rsp_strobe && rsp_status == ST_PAD, rsp_sample_value == '0)
   `ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_strobe && rsp_last_of_frame, !rsp_strobe)
   `ASSERT_NEXT(a_frame_contiguous, clock, reset, rsp_strobe && !rsp_last_of_frame, rsp_strobe && rsp_status == $past(rsp_status))

endmodule

bind frame_ring_sequence_buffer_core frsb_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_strobe        (rsp_strobe),
   .rsp_sample_value  (rsp_sample_value),
   .rsp_status        (rsp_status),
   .rsp_last_of_frame (rsp_last_of_frame)
);
